FILE: rtl/ipmm_pkg.sv
`default_nettype none
package ipmm_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_MATCH = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [2:0] StAdded   = 3'd0;
  localparam logic [2:0] StDup     = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StBadLen  = 3'd3;
  localparam logic [2:0] StHit     = 3'd4;
  localparam logic [2:0] StNoMatch = 3'd5;
  localparam logic [2:0] StCleared = 3'd6;

  // one stored subnet: family, length, index, prefix
  typedef struct packed {
    logic        is_ipv6;
    logic [7:0]  length;
    logic [31:0] ext_index;
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // top n bits of a 64-bit word, n in 0..64
  function automatic logic [63:0] top_bits(input logic [7:0] n);
    logic [63:0] m;
    m = '0;
    if (n >= 8'd64) m = '1;
    else if (n != 8'd0) m = ~(64'h0) << (7'd64 - n[6:0]);
    return m;
  endfunction

  function automatic logic [63:0] mask_high(input logic v6, input logic [7:0] len);
    return v6 ? top_bits(len > 8'd64 ? 8'd64 : len) : 64'h0;
  endfunction

  function automatic logic [63:0] mask_low(input logic v6, input logic [7:0] len);
    logic [63:0] m;
    m = top_bits(len);
    return v6 ? top_bits(len > 8'd64 ? len - 8'd64 : 8'd0) : (m >> 32);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ipmm_ram.sv
`default_nettype none
module ipmm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/ip_prefix_multi_match_table_core.sv
// One item at a time: in_stall_o holds off the next request until the core is back in idle
// and its last response word has been taken. Clear and a bad length are answered from idle;
// an add scans the entry RAM once for a duplicate and a free slot; a match scans it once for
// hits, then for each hit makes a full selection scan of the entry RAM (single read port)
// and emits one word.
// Reset: asynchronous, active low; clears valid bits and control, the RAM contents are never
// used unless marked valid.
`default_nettype none
module ip_prefix_multi_match_table_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic        is_ipv6_i,
  input  wire logic [63:0] address_high_i,
  input  wire logic [63:0] address_low_i,
  input  wire logic [7:0]  prefix_length_i,
  input  wire logic [31:0] subnet_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [31:0]      match_index_o,
  output logic             last_o
);
  import ipmm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ADD_END, S_SEL, S_EMIT, S_RESP
  } state_e;

  state_e state_q;
  logic [TableEntries-1:0] valid_q;
  logic [TableEntries-1:0] hit_q;     // entries still to report
  logic [1:0]   op_q;
  logic         v6_q;
  logic [63:0]  ah_q, al_q;
  logic [7:0]   len_q;
  logic [31:0]  xidx_q;
  logic [CntW-1:0] cnt_q;             // RAM address issued
  logic         rd_vld_q;             // read data valid this cycle
  logic [IdxW-1:0] rd_idx_q;
  logic         dup_q, free_q;
  logic [IdxW-1:0] slot_q;
  // selection pass
  logic         best_ok_q;
  logic [7:0]   best_len_q;
  logic [31:0]  best_idx_q;
  logic [IdxW-1:0] best_pos_q;

  // output register
  logic        ov_q;
  logic [2:0]  st_q;
  logic [31:0] mi_q;
  logic        last_q;

  // entry RAM
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, rdata;
  logic [EntryW-1:0] rdata_raw;

  ipmm_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  assign in_stall_o    = (state_q != S_IDLE) || ov_q;
  assign out_valid_o   = ov_q;
  assign status_o      = st_q;
  assign match_index_o = mi_q;
  assign last_o        = last_q;

  wire accept = in_valid_i && !in_stall_o;
  wire out_free = !ov_q || !out_stall_i;
  // output register reloaded this cycle
  wire ov_load = out_free &&
                 (state_q == S_ADD_END || state_q == S_EMIT || state_q == S_RESP);

  // masked input prefix
  logic [63:0] mh_in, ml_in;
  assign mh_in = mask_high(v6_q, len_q);
  assign ml_in = mask_low(v6_q, len_q);

  assign raddr = cnt_q[IdxW-1:0];
  assign waddr = slot_q;
  assign wdata = '{is_ipv6: v6_q, length: len_q, ext_index: xidx_q,
                   prefix_high: ah_q & mh_in, prefix_low: al_q & ml_in};
  assign we = (state_q == S_ADD_END) && !dup_q && free_q && out_free;

  // compare of the entry read back
  logic e_ok, e_dup, e_hit;
  logic [63:0] emh, eml;
  always_comb begin
    emh = mask_high(v6_q, rdata.length);
    eml = mask_low(v6_q, rdata.length);
    e_ok = rd_vld_q && valid_q[rd_idx_q] && (rdata.is_ipv6 == v6_q);
    e_dup = e_ok && rdata.length == len_q && rdata.prefix_high == (ah_q & mh_in)
            && rdata.prefix_low == (al_q & ml_in) && rdata.ext_index == xidx_q;
    e_hit = e_ok && ((ah_q & emh) == rdata.prefix_high)
            && ((al_q & eml) == rdata.prefix_low);
  end

  // entry before the current best in report order
  wire better = !best_ok_q || (rdata.length < best_len_q) ||
                (rdata.length == best_len_q &&
                 $signed(rdata.ext_index) < $signed(best_idx_q));
  wire sel_cand = rd_vld_q && hit_q[rd_idx_q];

  // control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      hit_q <= '0;
      ov_q <= 1'b0;
      cnt_q <= '0;
      rd_vld_q <= 1'b0;
      dup_q <= 1'b0;
      free_q <= 1'b0;
      best_ok_q <= 1'b0;
    end else begin
      if (ov_q && !out_stall_i && !ov_load) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q <= opcode_i;
            v6_q <= is_ipv6_i;
            ah_q <= is_ipv6_i ? address_high_i : 64'h0;
            al_q <= is_ipv6_i ? address_low_i : {32'h0, address_low_i[31:0]};
            len_q <= prefix_length_i;
            xidx_q <= subnet_index_i;
            cnt_q <= '0;
            rd_vld_q <= 1'b0;
            dup_q <= 1'b0;
            free_q <= 1'b0;
            hit_q <= '0;
            unique case (op_e'(opcode_i))
              OP_ADD: begin
                if (prefix_length_i > (is_ipv6_i ? 8'd128 : 8'd32)) begin
                  ov_q <= 1'b1; st_q <= StBadLen; mi_q <= '0; last_q <= 1'b1;
                end else state_q <= S_SCAN;
              end
              OP_MATCH: state_q <= S_SCAN;
              OP_CLEAR: begin
                valid_q <= '0;
                ov_q <= 1'b1; st_q <= StCleared; mi_q <= '0; last_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // issue reads, evaluate the previous one
          rd_vld_q <= (cnt_q < CntW'(TableEntries));
          rd_idx_q <= cnt_q[IdxW-1:0];
          if (cnt_q < CntW'(TableEntries)) cnt_q <= cnt_q + 1'b1;
          if (rd_vld_q) begin
            if (!valid_q[rd_idx_q] && !free_q) begin
              free_q <= 1'b1; slot_q <= rd_idx_q;
            end
            if (e_dup) dup_q <= 1'b1;
            if (e_hit) hit_q[rd_idx_q] <= 1'b1;
          end
          if (cnt_q == CntW'(TableEntries) && rd_vld_q) begin
            state_q <= (op_e'(op_q) == OP_ADD) ? S_ADD_END : S_SEL;
            cnt_q <= '0;
            best_ok_q <= 1'b0;
          end
        end
        S_ADD_END: begin
          if (out_free) begin
            ov_q <= 1'b1; mi_q <= '0; last_q <= 1'b1;
            st_q <= dup_q ? StDup : (free_q ? StAdded : StFull);
            if (!dup_q && free_q) valid_q[slot_q] <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_SEL: begin
          if (hit_q == '0) begin
            state_q <= S_RESP;
          end else begin
            rd_vld_q <= (cnt_q < CntW'(TableEntries));
            rd_idx_q <= cnt_q[IdxW-1:0];
            if (cnt_q < CntW'(TableEntries)) cnt_q <= cnt_q + 1'b1;
            if (sel_cand && better) begin
              best_ok_q <= 1'b1;
              best_len_q <= rdata.length;
              best_idx_q <= rdata.ext_index;
              best_pos_q <= rd_idx_q;
            end
            if (cnt_q == CntW'(TableEntries) && rd_vld_q) begin
              state_q <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            ov_q <= 1'b1; st_q <= StHit; mi_q <= best_idx_q;
            last_q <= (hit_q & ~(TableEntries'(1) << best_pos_q)) == '0;
            hit_q[best_pos_q] <= 1'b0;
            best_ok_q <= 1'b0;
            cnt_q <= '0;
            state_q <= ((hit_q & ~(TableEntries'(1) << best_pos_q)) == '0)
                       ? S_IDLE : S_SEL;
          end
        end
        S_RESP: begin
          // reached only when nothing matched
          if (out_free) begin
            ov_q <= 1'b1; st_q <= StNoMatch; mi_q <= '0; last_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: dv/ip_prefix_multi_match_table_core_tb.sv
`default_nettype none
module ip_prefix_multi_match_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ipmm_pkg::*;

  localparam int Depth = 64;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic        is_ipv6_i;
  logic [63:0] address_high_i;
  logic [63:0] address_low_i;
  logic [7:0]  prefix_length_i;
  logic [31:0] subnet_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [31:0] match_index_o;
  logic        last_o;

  ip_prefix_multi_match_table_core i_dut (.*);

  // one request word and one response word
  typedef struct packed {
    op_e         op;
    logic        v6;
    logic [63:0] ah;
    logic [63:0] al;
    logic [7:0]  len;
    logic [31:0] idx;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] idx;
    logic        last;
  } rsp_t;

  // directed row: request plus optional hand-typed response
  typedef struct packed {
    req_t        req;
    logic        has_rsp;
    rsp_t        rsp;
  } row_t;

  // shadow of the subnet table
  logic        tbl_valid [Depth];
  logic        tbl_v6    [Depth];
  logic [63:0] tbl_ph    [Depth];
  logic [63:0] tbl_pl    [Depth];
  logic [7:0]  tbl_len   [Depth];
  logic [31:0] tbl_idx   [Depth];

  rsp_t rsp_q[$];
  row_t dir[$];
  int   n_fail;
  bit   hold_long;
  bit   no_idle;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // append an expected response word
  function automatic void queue_rsp(input rsp_t w);
    rsp_q.insert(rsp_q.size(), w);
  endfunction

  // append a directed row
  function automatic void add_row(input row_t r);
    dir.insert(dir.size(), r);
  endfunction

  function automatic logic [63:0] top_n(input int n);
    if (n <= 0) return 64'h0;
    if (n >= 64) return '1;
    return ~64'h0 << (64 - n);
  endfunction

  function automatic void prefix_masks(input logic v6, input int len,
                                       output logic [63:0] mh, output logic [63:0] ml);
    if (v6) begin
      mh = top_n(len > 64 ? 64 : len);
      ml = top_n(len > 64 ? len - 64 : 0);
    end else begin
      mh = 64'h0;
      ml = top_n(len) >> 32;
    end
  endfunction

  // compute responses for one request and update the shadow table
  function automatic void predict_lookup(input req_t r);
    logic [63:0] ah, al, mh, ml;
    int slot, n, j;
    int hits[Depth];
    rsp_t w;
    ah = r.v6 ? r.ah : 64'h0;
    al = r.v6 ? r.al : {32'h0, r.al[31:0]};
    w = '{status: StAdded, idx: 32'h0, last: 1'b1};
    case (r.op)
      OP_ADD: begin
        if (r.len > (r.v6 ? 8'd128 : 8'd32)) begin
          w.status = StBadLen;
        end else begin
          prefix_masks(r.v6, r.len, mh, ml);
          ah &= mh;
          al &= ml;
          slot = -1;
          for (int i = 0; i < Depth; i++) begin
            if (!tbl_valid[i]) begin
              if (slot < 0) slot = i;
            end else if (tbl_v6[i] == r.v6 && tbl_len[i] == r.len && tbl_ph[i] == ah
                         && tbl_pl[i] == al && tbl_idx[i] == r.idx && w.status == StAdded) begin
              w.status = StDup;
            end
          end
          if (w.status == StAdded) begin
            if (slot < 0) w.status = StFull;
            else begin
              tbl_valid[slot] = 1'b1;
              tbl_v6[slot] = r.v6;
              tbl_ph[slot] = ah;
              tbl_pl[slot] = al;
              tbl_len[slot] = r.len;
              tbl_idx[slot] = r.idx;
            end
          end
        end
        queue_rsp(w);
      end
      OP_MATCH: begin
        n = 0;
        for (int i = 0; i < Depth; i++) begin
          if (tbl_valid[i] && tbl_v6[i] == r.v6) begin
            prefix_masks(r.v6, tbl_len[i], mh, ml);
            if ((ah & mh) == tbl_ph[i] && (al & ml) == tbl_pl[i]) begin
              j = n;
              while (j > 0 && (tbl_len[i] < tbl_len[hits[j-1]] ||
                     (tbl_len[i] == tbl_len[hits[j-1]] &&
                      $signed(tbl_idx[i]) < $signed(tbl_idx[hits[j-1]])))) begin
                hits[j] = hits[j-1];
                j--;
              end
              hits[j] = i;
              n++;
            end
          end
        end
        if (n == 0) begin
          w.status = StNoMatch;
          queue_rsp(w);
        end
        for (int i = 0; i < n; i++) begin
          w = '{status: StHit, idx: tbl_idx[hits[i]], last: (i == n - 1)};
          queue_rsp(w);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < Depth; i++) tbl_valid[i] = 1'b0;
        w.status = StCleared;
        queue_rsp(w);
      end
      default: ;
    endcase
  endfunction

  // present one word, hold until accepted
  task automatic send_word(input req_t r);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= r.op;
    is_ipv6_i       <= r.v6;
    address_high_i  <= r.ah;
    address_low_i   <= r.al;
    prefix_length_i <= r.len;
    subnet_index_i  <= r.idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_lookup(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // random request biased towards a small set of subnets
  function automatic req_t rand_req();
    req_t r;
    int p;
    r.v6  = 1'($urandom_range(1));
    r.ah  = {$urandom, $urandom};
    r.al  = {$urandom, $urandom};
    if ($urandom_range(3) != 0) begin
      // few distinct network bits so matches hit
      r.ah = {4'($urandom_range(3)), r.ah[59:0]};
      r.al = {r.al[63:32], 4'($urandom_range(3)), r.al[27:0]};
    end
    r.idx = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(15)) - 32'd8;
    p = $urandom_range(99);
    if (p < 45) r.op = OP_ADD;
    else if (p < 92) r.op = OP_MATCH;
    else if (p < 96) r.op = OP_CLEAR;
    else r.op = OP_NONE;
    if ($urandom_range(19) == 0) r.len = 8'($urandom);
    else r.len = r.v6 ? 8'($urandom_range(12)) : 8'($urandom_range(6));
    if ($urandom_range(9) == 0) r.len = r.v6 ? 8'd128 : 8'd32;
    return r;
  endfunction

  // receiver: random stalls and a long hold
  initial begin
    out_stall_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
        hold_long = 1'b0;
      end
      out_stall_i <= !no_idle && ($urandom_range(99) < 33);
    end
  end

  // compare accepted responses
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rsp_q.size() == 0) begin
        $error("unexpected response status %0d", status_o);
        n_fail++;
      end else begin
        e = rsp_q.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o);
          n_fail++;
        end
        if (match_index_o !== e.idx) begin
          $error("match_index exp %0d got %0d", $signed(e.idx), $signed(match_index_o));
          n_fail++;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    n_fail = 0;
    hold_long = 0;
    no_idle = 0;
    for (int i = 0; i < Depth; i++) tbl_valid[i] = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = OP_NONE;
    is_ipv6_i = 1'b0;
    address_high_i = '0;
    address_low_i = '0;
    prefix_length_i = '0;
    subnet_index_i = '0;

    // directed table
    add_row('{'{OP_MATCH, 1'b0, 64'h0, 64'h0, 8'd0, 32'h0}, 1'b1,
              '{StNoMatch, 32'h0, 1'b1}});
    add_row('{'{OP_ADD, 1'b0, 64'h0, 64'h0, 8'd33, 32'h0}, 1'b1,
              '{StBadLen, 32'h0, 1'b1}});
    add_row('{'{OP_ADD, 1'b1, '1, '1, 8'd129, 32'h0}, 1'b1,
              '{StBadLen, 32'h0, 1'b1}});
    add_row('{'{OP_ADD, 1'b1, '1, '1, 8'd255, '1}, 1'b1, '{StBadLen, 32'h0, 1'b1}});
    add_row('{'{OP_ADD, 1'b0, '1, '1, 8'd0, 32'h8000_0000}, 1'b1,
              '{StAdded, 32'h0, 1'b1}});
    add_row('{'{OP_ADD, 1'b0, 64'h0, 64'h0, 8'd0, 32'h8000_0000}, 1'b1,
              '{StDup, 32'h0, 1'b1}});
    add_row('{'{OP_ADD, 1'b0, '1, 64'hFFFF_FFFF_C0A8_0101, 8'd32, 32'h7FFF_FFFF},
              1'b0, '0});
    add_row('{'{OP_ADD, 1'b0, 64'h0, 64'hC0A8_0000, 8'd16, 32'h7FFF_FFFF}, 1'b0, '0});
    add_row('{'{OP_ADD, 1'b0, 64'h0, 64'hC0A8_0000, 8'd16, '1}, 1'b0, '0});
    add_row('{'{OP_MATCH, 1'b0, '1, 64'h1234_5678_C0A8_0101, 8'd7, 32'h0}, 1'b0, '0});
    add_row('{'{OP_ADD, 1'b1, 64'h0, 64'h0, 8'd0, 32'h0}, 1'b0, '0});
    add_row('{'{OP_ADD, 1'b1, '1, '1, 8'd128, 32'h5}, 1'b0, '0});
    add_row('{'{OP_ADD, 1'b1, 64'hFFFF_0000_0000_0000, 64'h0, 8'd64, 32'h6}, 1'b0, '0});
    add_row('{'{OP_ADD, 1'b1, '1, 64'h8000_0000_0000_0000, 8'd65, 32'h7}, 1'b0, '0});
    add_row('{'{OP_MATCH, 1'b1, '1, '1, 8'd0, 32'h0}, 1'b0, '0});
    add_row('{'{OP_MATCH, 1'b1, 64'h0, 64'h1, 8'd0, 32'h0}, 1'b0, '0});
    add_row('{'{OP_NONE, 1'b1, '1, '1, '1, '1}, 1'b0, '0});
    add_row('{'{OP_CLEAR, 1'b0, 64'h0, 64'h0, 8'd0, 32'h0}, 1'b1,
              '{StCleared, 32'h0, 1'b1}});
    add_row('{'{OP_MATCH, 1'b1, '1, '1, 8'd0, 32'h0}, 1'b1, '{StNoMatch, 32'h0, 1'b1}});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: a typed response replaces the predicted word
    foreach (dir[k]) begin
      send_word(dir[k].req);
      if (dir[k].has_rsp && rsp_q.size() != 0) rsp_q[rsp_q.size()-1] = dir[k].rsp;
    end
    drain();

    // fill the table to full, then duplicate on a full table
    for (int i = 0; i < Depth + 2; i++)
      send_word('{OP_ADD, 1'b0, 64'h0, 64'($urandom), 8'd0, 32'(i)});
    send_word('{OP_ADD, 1'b0, 64'h0, 64'h0, 8'd0, 32'd3});
    send_word('{OP_MATCH, 1'b0, 64'h0, 64'h0, 8'd0, 32'd0});
    send_word('{OP_CLEAR, 1'b0, 64'h0, 64'h0, 8'd0, 32'd0});
    drain();

    // random traffic with a long receiver hold and a quiet stretch
    for (int n = 0; n < 120; n++) begin
      if (n == 30) hold_long = 1'b1;
      no_idle = (n >= 60 && n < 90);
      if (n == 100) drain();
      send_word(rand_req());
    end
    drain();
    in_valid_i <= 1'b0;
    repeat (200) @(posedge clk_i);
    if (n_fail == 0 && rsp_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/ipmm_pkg.sv
rtl/ipmm_ram.sv
rtl/ip_prefix_multi_match_table_core.sv
dv/ip_prefix_multi_match_table_core_tb.sv
